>>> rtl/core/bb3_pkg.sv
// shared types, constants and helpers for the 3x3 rgb box blur
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int SLOT_W     = 2;
    localparam int ADDR_W     = SLOT_W + POS_W;
    localparam int MEM_DEPTH  = 3 * MAX_WIDTH;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 13;
    localparam int DEN_W      = 5;
    localparam int QUOT_W     = 8;

    localparam logic [SIZE_W-1:0] SIZE_MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_MAX_H = SIZE_W'(MAX_HEIGHT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    // store slot holding the row delta rows above the current one
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] rot,
                                                  input logic [1:0] delta);
        logic [SLOT_W-1:0] s;
        if (rot >= delta) s = rot - delta;
        else s = rot + 2'd3 - delta;
        return s;
    endfunction

    // clamp a size register into 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] vmax);
        logic [SIZE_W-1:0] s;
        if (v == '0) s = SIZE_W'(1);
        else if (v > vmax) s = vmax;
        else s = v;
        return s;
    endfunction

endpackage

>>> rtl/core/bb3_div.sv
// iterative restoring divider, one quotient bit per cycle
module bb3_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bb3_pkg::NUM_W-1:0]  i_num,
    input  logic [bb3_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [bb3_pkg::QUOT_W-1:0] o_quot
);

    logic                       r_busy;
    logic                       r_done;
    logic [2:0]                 r_k;
    logic [bb3_pkg::NUM_W-1:0]  r_rem;
    logic [bb3_pkg::DEN_W-1:0]  r_den;
    logic [bb3_pkg::QUOT_W-1:0] r_quot;
    logic [bb3_pkg::NUM_W:0]    w_trial;

    assign w_trial = {1'b0, r_rem} - ({{(bb3_pkg::NUM_W + 1 - bb3_pkg::DEN_W){1'b0}}, r_den}
                                      << r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_k    <= 3'd7;
            r_quot <= '0;
        end else if (r_busy) begin
            if (!w_trial[bb3_pkg::NUM_W]) begin
                r_rem       <= w_trial[bb3_pkg::NUM_W-1:0];
                r_quot[r_k] <= 1'b1;
            end
            r_k <= r_k - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/core/box_blur_3x3_rgb.sv
// top level: streaming 3x3 rgb box blur with clipped neighborhood
// one input word is taken in idle, then 0 to 4 output words follow one at a time
// each output word: setup, 1 to 9 row store reads, drain, one divider run per channel, then out
// the out state holds each word until the output handshake, and no input is taken meanwhile
// the single shared divider and the one-read row store port serialize this work
// synchronous active-low reset clears position, rotation and size registers (sizes to 1)
module box_blur_3x3_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row, out_col, out_red, out_green, out_blue, pad
    output logic        m_axis_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = bb3_pkg::POS_W;
    localparam int SW = bb3_pkg::SIZE_W;

    bb3_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_width, r_height;
    logic [PW-1:0] r_row, r_col;
    logic [1:0]    r_rot;

    logic [PW-1:0] r_cur_r, r_cur_c;
    logic [1:0]    r_cur_rot;
    logic [3:0]    r_mask;
    logic [1:0]    r_sel;
    logic [PW-1:0] r_i, r_j, r_m, r_n, r_m_hi, r_n_lo, r_n_hi;
    logic          r_rd_vld;
    logic [bb3_pkg::PIX_W-1:0] r_rd_data;
    logic [bb3_pkg::SUM_W-1:0] r_sum [3];
    logic [bb3_pkg::CNT_W-1:0] r_cnt;
    logic [1:0]    r_ch;
    logic [7:0]    r_res [3];

    logic [bb3_pkg::PIX_W-1:0] mem [bb3_pkg::MEM_DEPTH];

    logic          w_cfg_wr, w_acc_in, w_out_hs;
    logic [SW-1:0] w_wc, w_hc;
    logic [PW-1:0] w_c_eff, w_r_eff;
    logic          w_last_c, w_last_r;
    logic [3:0]    w_mask;
    logic [1:0]    w_first;
    logic          w_any;
    logic [1:0]    w_next;
    logic          w_has_next;
    logic [PW-1:0] w_i, w_j, w_m_lo, w_m_hi, w_n_lo, w_n_hi;
    logic [1:0]    w_delta;
    logic [bb3_pkg::ADDR_W-1:0] w_rd_addr;
    logic          w_rd_en, w_div_start, w_div_done;
    logic [bb3_pkg::NUM_W-1:0]  w_num;
    logic [bb3_pkg::DEN_W-1:0]  w_den;
    logic [7:0]    w_quot;
    logic [bb3_pkg::SUM_W-1:0]  w_sum_sel;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = paddr[2] ? {21'd0, r_height} : {21'd0, r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SW'(1);
            r_height <= SW'(1);
        end else if (w_cfg_wr) begin
            if (paddr[2]) r_height <= pwdata[SW-1:0];
            else r_width <= pwdata[SW-1:0];
        end
    end

    assign w_wc = bb3_pkg::clamp_size(r_width, bb3_pkg::SIZE_MAX_W);
    assign w_hc = bb3_pkg::clamp_size(r_height, bb3_pkg::SIZE_MAX_H);

    assign w_c_eff  = ({1'b0, r_col} >= w_wc) ? PW'(w_wc - SW'(1)) : r_col;
    assign w_r_eff  = ({1'b0, r_row} >= w_hc) ? PW'(w_hc - SW'(1)) : r_row;
    assign w_last_c = ({1'b0, w_c_eff} == w_wc - SW'(1));
    assign w_last_r = ({1'b0, w_r_eff} == w_hc - SW'(1));

    assign w_mask[0] = (w_r_eff != '0) && (w_c_eff != '0);
    assign w_mask[1] = (w_r_eff != '0) && w_last_c;
    assign w_mask[2] = w_last_r && (w_c_eff != '0);
    assign w_mask[3] = w_last_r && w_last_c;

    always_comb begin
        w_first = 2'd0;
        w_any   = 1'b0;
        for (int k = 3; k >= 0; k--) begin
            if (w_mask[k]) begin
                w_first = 2'(k);
                w_any   = 1'b1;
            end
        end
        w_next     = 2'd0;
        w_has_next = 1'b0;
        for (int k = 3; k >= 0; k--) begin
            if (r_mask[k] && 2'(k) > r_sel) begin
                w_next     = 2'(k);
                w_has_next = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == bb3_pkg::ST_IDLE);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == bb3_pkg::ST_OUT);
    assign w_out_hs      = m_axis_tvalid && m_axis_tready;

    // window bounds of the output word selected by r_sel
    assign w_i    = r_sel[1] ? r_cur_r : r_cur_r - PW'(1);
    assign w_j    = r_sel[0] ? r_cur_c : r_cur_c - PW'(1);
    assign w_m_lo = (w_i != '0) ? w_i - PW'(1) : '0;
    assign w_n_lo = (w_j != '0) ? w_j - PW'(1) : '0;
    assign w_m_hi = ({1'b0, w_i} + SW'(1) < w_hc) ? w_i + PW'(1) : PW'(w_hc - SW'(1));
    assign w_n_hi = ({1'b0, w_j} + SW'(1) < w_wc) ? w_j + PW'(1) : PW'(w_wc - SW'(1));

    assign w_delta   = 2'(r_cur_r - r_m);
    assign w_rd_addr = {bb3_pkg::slot_of(r_cur_rot, w_delta), r_n};
    assign w_rd_en   = (r_state == bb3_pkg::ST_READ);

    always_ff @(posedge i_clk) begin
        if (w_acc_in) mem[{r_rot, w_c_eff}] <= s_axis_tdata;
        if (w_rd_en) r_rd_data <= mem[w_rd_addr];
    end

    always_comb begin
        case (r_ch)
            2'd0:    w_sum_sel = r_sum[0];
            2'd1:    w_sum_sel = r_sum[1];
            default: w_sum_sel = r_sum[2];
        endcase
    end

    assign w_num       = {w_sum_sel, 1'b0} + bb3_pkg::NUM_W'(r_cnt);
    assign w_den       = {r_cnt, 1'b0};
    assign w_div_start = (r_state == bb3_pkg::ST_DIV_GO);

    bb3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bb3_pkg::ST_IDLE:     if (w_acc_in && w_any) n_state = bb3_pkg::ST_SETUP;
            bb3_pkg::ST_SETUP:    n_state = bb3_pkg::ST_READ;
            bb3_pkg::ST_READ:     if (r_n == r_n_hi && r_m == r_m_hi) n_state = bb3_pkg::ST_DRAIN;
            bb3_pkg::ST_DRAIN:    n_state = bb3_pkg::ST_DIV_GO;
            bb3_pkg::ST_DIV_GO:   n_state = bb3_pkg::ST_DIV_WAIT;
            bb3_pkg::ST_DIV_WAIT: begin
                if (w_div_done) n_state = (r_ch == 2'd2) ? bb3_pkg::ST_OUT : bb3_pkg::ST_DIV_GO;
            end
            bb3_pkg::ST_OUT: begin
                if (w_out_hs) n_state = w_has_next ? bb3_pkg::ST_SETUP : bb3_pkg::ST_IDLE;
            end
            default:              n_state = bb3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bb3_pkg::ST_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_rot    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (w_acc_in) begin
                if (w_last_c) begin
                    r_col <= '0;
                    r_rot <= (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
                    r_row <= w_last_r ? '0 : w_r_eff + PW'(1);
                end else begin
                    r_col <= w_c_eff + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_cur_r   <= w_r_eff;
            r_cur_c   <= w_c_eff;
            r_cur_rot <= r_rot;
            r_mask    <= w_mask;
            r_sel     <= w_first;
        end
        if (r_state == bb3_pkg::ST_SETUP) begin
            r_i    <= w_i;
            r_j    <= w_j;
            r_m    <= w_m_lo;
            r_m_hi <= w_m_hi;
            r_n    <= w_n_lo;
            r_n_lo <= w_n_lo;
            r_n_hi <= w_n_hi;
            r_cnt  <= '0;
            r_ch   <= 2'd0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end
        if (r_state == bb3_pkg::ST_READ) begin
            if (r_n == r_n_hi) begin
                r_n <= r_n_lo;
                r_m <= r_m + PW'(1);
            end else begin
                r_n <= r_n + PW'(1);
            end
        end
        if (r_rd_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= r_sum[k] + bb3_pkg::SUM_W'(r_rd_data[8*k +: 8]);
            end
            r_cnt <= r_cnt + bb3_pkg::CNT_W'(1);
        end
        if (r_state == bb3_pkg::ST_DIV_WAIT && w_div_done) begin
            r_res[r_ch] <= w_quot;
            r_ch        <= r_ch + 2'd1;
        end
        if (w_out_hs && w_has_next) r_sel <= w_next;
    end

    assign m_axis_tdata = {4'd0, r_res[2], r_res[1], r_res[0], r_j, r_i};
    assign m_axis_tlast = !w_has_next;

    a_ready_not_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output word pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_cnt != '0 && r_cnt <= bb3_pkg::CNT_W'(9)))
        else $error("neighborhood count out of range");

    a_sel_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bb3_pkg::ST_OUT) |-> r_mask[r_sel])
        else $error("output word not released by this pixel");

endmodule

>>> tb/tb.sv
// testbench for the streaming 3x3 rgb box blur: directed and random images checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_WIDTH  = 0;
    localparam int REG_HEIGHT = 1;
    localparam int LIMIT      = 20000;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_word;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_blur_3x3_rgb dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // predictor state
    logic [23:0] pix_rows [3][bb3_pkg::MAX_WIDTH];
    int unsigned cfg_w = 1, cfg_h = 1;
    int unsigned cur_r = 0, cur_c = 0, rot = 0;
    t_blur_word  blur_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int unsigned out_wait = 0;

    function automatic int unsigned eff_size(int unsigned v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic t_blur_word blur_at(int unsigned r, int unsigned i, int unsigned j,
                                           int unsigned w, int unsigned h);
        t_blur_word  o;
        int unsigned sr = 0, sg = 0, sb = 0, cnt = 0, mlo, mhi, nlo, nhi, slot;
        mlo = (i > 0) ? i - 1 : 0;
        mhi = (i + 1 < h) ? i + 1 : h - 1;
        nlo = (j > 0) ? j - 1 : 0;
        nhi = (j + 1 < w) ? j + 1 : w - 1;
        for (int unsigned m = mlo; m <= mhi; m++) begin
            if (m > r || r - m > 2) continue;
            slot = (rot + 3 - (r - m)) % 3;
            for (int unsigned n = nlo; n <= nhi; n++) begin
                sr += pix_rows[slot][n][7:0];
                sg += pix_rows[slot][n][15:8];
                sb += pix_rows[slot][n][23:16];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        o.row   = i[9:0];
        o.col   = j[9:0];
        o.red   = 8'((2 * sr + cnt) / (2 * cnt));
        o.green = 8'((2 * sg + cnt) / (2 * cnt));
        o.blue  = 8'((2 * sb + cnt) / (2 * cnt));
        o.last  = 0;
        return o;
    endfunction

    task automatic predict_blur(logic [23:0] px);
        int unsigned w, h, r, c, nr = 0, nc = 0, k = 0;
        int unsigned rows [2], cols [2];
        bit lc, lr;
        t_blur_word o;
        w = eff_size(cfg_w);
        h = eff_size(cfg_h);
        r = (cur_r >= h) ? h - 1 : cur_r;
        c = (cur_c >= w) ? w - 1 : cur_c;
        pix_rows[rot][c] = px;
        lc = (c == w - 1);
        lr = (r == h - 1);
        if (r >= 1) rows[nr++] = r - 1;
        if (lr) rows[nr++] = r;
        if (c >= 1) cols[nc++] = c - 1;
        if (lc) cols[nc++] = c;
        for (int a = 0; a < nr; a++)
            for (int b = 0; b < nc; b++) begin
                o = blur_at(r, rows[a], cols[b], w, h);
                k++;
                o.last = (k == nr * nc);
                blur_q.push_back(o);
            end
        if (lc) begin
            cur_c = 0;
            rot = (rot + 1) % 3;
            cur_r = lr ? 0 : r + 1;
        end else begin
            cur_c = c + 1;
        end
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 3'(4 * idx); pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_WIDTH) cfg_w = val[10:0];
        else cfg_h = val[10:0];
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [23:0] px);
        int unsigned gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_blur(px);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic send_image(int unsigned n, bit extremes);
        logic [23:0] px;
        for (int unsigned k = 0; k < n; k++) begin
            px = $urandom;
            if (extremes) px = ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h000000;
            send_pixel(px);
        end
    endtask

    task automatic test_directed();
        // single pixel image, extremes, width 0, oversized width shrunk mid row, single column and single row
        set_size(1, 1);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        set_size(3, 3);
        send_image(9, 1);
        set_size(0, 2);
        send_image(2, 0);
        set_size(2047, 1);
        send_image(4, 0);
        set_size(4, 1);
        send_image(1, 0);
        set_size(1, 5);
        send_image(5, 0);
        set_size(5, 1);
        send_image(5, 0);
    endtask

    task automatic test_random();
        int unsigned w, h;
        for (int k = 0; k < 19; k++) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            set_size(w, h);
            send_image(w * h, k == 3);
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        t_blur_word got, exp_w;
        int unsigned gap;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[27:20],
                       m_axis_tdata[35:28], m_axis_tdata[43:36], m_axis_tlast};
                if (blur_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %p", got);
                end else begin
                    exp_w = blur_q.pop_front();
                    if (got !== exp_w) begin
                        errors++;
                        if (errors <= 10) $display("mismatch exp %p got %p", exp_w, got);
                    end
                end
                gap = $urandom_range(0, 5);
                out_wait <= gap;
                m_axis_tready <= (gap == 0);
            end else if (m_axis_tvalid && !m_axis_tready) begin
                if (out_wait <= 1) m_axis_tready <= 1;
                out_wait <= (out_wait == 0) ? 0 : out_wait - 1;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_drained();
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
